/* sv/rls_pkg.sv */
// rls_pkg: shared types, codes and the microcode table of the recursive least squares estimator
// number format helpers for signed Q16.16 with saturation
// no dependencies
package rls_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int MAG_W  = DATA_W + FRAC_W;   // magnitude width of products and quotients
  localparam int PC_W   = 6;
  localparam int SEL_W  = 5;
  localparam int RF_AW  = 4;

  localparam logic signed [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] HUNDRED = DATA_W'(100) << FRAC_W;

  // configuration register indexes
  localparam logic [2:0] CFG_FORGETTING = 3'd0;
  localparam logic [2:0] CFG_A0         = 3'd1;
  localparam logic [2:0] CFG_B0         = 3'd2;
  localparam logic [2:0] CFG_P1         = 3'd3;
  localparam logic [2:0] CFG_P2         = 3'd4;

  // micro-operations
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_BZS,   // branch if operand a is zero, mark update skipped
    OP_BZI,   // branch if operand a is zero, mark gains invalid
    OP_JMP,
    OP_END
  } op_t;

  // register file entries
  localparam logic [SEL_W-1:0] R_TH0  = 5'd0;
  localparam logic [SEL_W-1:0] R_TH1  = 5'd1;
  localparam logic [SEL_W-1:0] R_C0   = 5'd2;
  localparam logic [SEL_W-1:0] R_C1   = 5'd3;
  localparam logic [SEL_W-1:0] R_C2   = 5'd4;
  localparam logic [SEL_W-1:0] R_C3   = 5'd5;
  localparam logic [SEL_W-1:0] R_T0   = 5'd6;
  localparam logic [SEL_W-1:0] R_T1   = 5'd7;
  localparam logic [SEL_W-1:0] R_PP0  = 5'd8;
  localparam logic [SEL_W-1:0] R_PP1  = 5'd9;
  localparam logic [SEL_W-1:0] R_DEN  = 5'd10;
  localparam logic [SEL_W-1:0] R_ERR  = 5'd11;
  localparam logic [SEL_W-1:0] R_G0   = 5'd12;
  localparam logic [SEL_W-1:0] R_G1   = 5'd13;
  localparam logic [SEL_W-1:0] R_AEST = 5'd14;

  // fixed operand sources
  localparam logic [SEL_W-1:0] S_Y    = 5'd16;
  localparam logic [SEL_W-1:0] S_U    = 5'd17;
  localparam logic [SEL_W-1:0] S_YC   = 5'd18;
  localparam logic [SEL_W-1:0] S_LAM  = 5'd19;
  localparam logic [SEL_W-1:0] S_P1   = 5'd20;
  localparam logic [SEL_W-1:0] S_P2   = 5'd21;
  localparam logic [SEL_W-1:0] S_A0   = 5'd22;
  localparam logic [SEL_W-1:0] S_B0   = 5'd23;
  localparam logic [SEL_W-1:0] S_ZERO = 5'd24;
  localparam logic [SEL_W-1:0] S_HUND = 5'd25;

  // result destinations outside the register file
  localparam logic [SEL_W-1:0] D_ERR  = 5'd16;
  localparam logic [SEL_W-1:0] D_A    = 5'd17;
  localparam logic [SEL_W-1:0] D_B    = 5'd18;
  localparam logic [SEL_W-1:0] D_KFB  = 5'd19;
  localparam logic [SEL_W-1:0] D_KREF = 5'd20;

  // program entry points
  localparam logic [PC_W-1:0] PC_RESTART = 6'd0;
  localparam logic [PC_W-1:0] PC_UPDATE  = 6'd7;
  localparam logic [PC_W-1:0] PC_TAIL    = 6'd41;
  localparam logic [PC_W-1:0] PC_LAST    = 6'd51;

  typedef struct packed {
    op_t              op;
    logic [SEL_W-1:0] dst;
    logic [SEL_W-1:0] srca;
    logic [SEL_W-1:0] srcb;
    logic [PC_W-1:0]  target;
  } uop_t;

  function automatic uop_t mk(op_t o, logic [SEL_W-1:0] d, logic [SEL_W-1:0] a,
                              logic [SEL_W-1:0] b, logic [PC_W-1:0] t);
    uop_t u;
    u.op     = o;
    u.dst    = d;
    u.srca   = a;
    u.srcb   = b;
    u.target = t;
    return u;
  endfunction

  // microcode: restart, update, then estimates and controller gains
  function automatic uop_t ucode(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_SUB, R_TH0, S_ZERO, S_A0,   '0);
      6'd1:  u = mk(OP_ADD, R_TH1, S_B0,   S_ZERO, '0);
      6'd2:  u = mk(OP_ADD, R_C0,  S_HUND, S_ZERO, '0);
      6'd3:  u = mk(OP_ADD, R_C1,  S_ZERO, S_ZERO, '0);
      6'd4:  u = mk(OP_ADD, R_C2,  S_ZERO, S_ZERO, '0);
      6'd5:  u = mk(OP_ADD, R_C3,  S_HUND, S_ZERO, '0);
      6'd6:  u = mk(OP_JMP, R_TH0, S_ZERO, S_ZERO, PC_TAIL);
      // prediction and error
      6'd7:  u = mk(OP_MUL, R_T0,  R_TH0,  S_Y,    '0);
      6'd8:  u = mk(OP_MUL, R_T1,  R_TH1,  S_U,    '0);
      6'd9:  u = mk(OP_ADD, R_T0,  R_T0,   R_T1,   '0);
      6'd10: u = mk(OP_SUB, R_ERR, S_YC,   R_T0,   '0);
      6'd11: u = mk(OP_ADD, D_ERR, R_ERR,  S_ZERO, '0);
      // covariance times regressor
      6'd12: u = mk(OP_MUL, R_T0,  R_C0,   S_Y,    '0);
      6'd13: u = mk(OP_MUL, R_T1,  R_C1,   S_U,    '0);
      6'd14: u = mk(OP_ADD, R_PP0, R_T0,   R_T1,   '0);
      6'd15: u = mk(OP_MUL, R_T0,  R_C2,   S_Y,    '0);
      6'd16: u = mk(OP_MUL, R_T1,  R_C3,   S_U,    '0);
      6'd17: u = mk(OP_ADD, R_PP1, R_T0,   R_T1,   '0);
      // denominator
      6'd18: u = mk(OP_MUL, R_T0,  S_Y,    R_PP0,  '0);
      6'd19: u = mk(OP_ADD, R_T0,  S_LAM,  R_T0,   '0);
      6'd20: u = mk(OP_MUL, R_T1,  S_U,    R_PP1,  '0);
      6'd21: u = mk(OP_ADD, R_DEN, R_T0,   R_T1,   '0);
      6'd22: u = mk(OP_BZS, R_TH0, R_DEN,  S_ZERO, PC_TAIL);
      // gain vector and parameter update
      6'd23: u = mk(OP_DIV, R_G0,  R_PP0,  R_DEN,  '0);
      6'd24: u = mk(OP_DIV, R_G1,  R_PP1,  R_DEN,  '0);
      6'd25: u = mk(OP_MUL, R_T0,  R_G0,   R_ERR,  '0);
      6'd26: u = mk(OP_ADD, R_TH0, R_TH0,  R_T0,   '0);
      6'd27: u = mk(OP_MUL, R_T0,  R_G1,   R_ERR,  '0);
      6'd28: u = mk(OP_ADD, R_TH1, R_TH1,  R_T0,   '0);
      // covariance update
      6'd29: u = mk(OP_MUL, R_T0,  R_G0,   R_PP0,  '0);
      6'd30: u = mk(OP_SUB, R_T0,  R_C0,   R_T0,   '0);
      6'd31: u = mk(OP_DIV, R_C0,  R_T0,   S_LAM,  '0);
      6'd32: u = mk(OP_MUL, R_T0,  R_G0,   R_PP1,  '0);
      6'd33: u = mk(OP_SUB, R_T0,  R_C1,   R_T0,   '0);
      6'd34: u = mk(OP_DIV, R_C1,  R_T0,   S_LAM,  '0);
      6'd35: u = mk(OP_MUL, R_T0,  R_G1,   R_PP0,  '0);
      6'd36: u = mk(OP_SUB, R_T0,  R_C2,   R_T0,   '0);
      6'd37: u = mk(OP_DIV, R_C2,  R_T0,   S_LAM,  '0);
      6'd38: u = mk(OP_MUL, R_T0,  R_G1,   R_PP1,  '0);
      6'd39: u = mk(OP_SUB, R_T0,  R_C3,   R_T0,   '0);
      6'd40: u = mk(OP_DIV, R_C3,  R_T0,   S_LAM,  '0);
      // estimates and pole-placement gains
      6'd41: u = mk(OP_SUB, R_AEST, S_ZERO, R_TH0, '0);
      6'd42: u = mk(OP_ADD, D_A,   R_AEST, S_ZERO, '0);
      6'd43: u = mk(OP_ADD, D_B,   R_TH1,  S_ZERO, '0);
      6'd44: u = mk(OP_BZI, R_TH0, R_TH1,  S_ZERO, PC_LAST);
      6'd45: u = mk(OP_ADD, R_T0,  S_P1,   S_P2,   '0);
      6'd46: u = mk(OP_SUB, R_T0,  S_ZERO, R_T0,   '0);
      6'd47: u = mk(OP_SUB, R_T0,  R_T0,   R_AEST, '0);
      6'd48: u = mk(OP_DIV, D_KFB, R_T0,   R_TH1,  '0);
      6'd49: u = mk(OP_MUL, R_T0,  S_P1,   S_P2,   '0);
      6'd50: u = mk(OP_DIV, D_KREF, R_T0,  R_TH1,  '0);
      default: u = mk(OP_END, R_TH0, S_ZERO, S_ZERO, '0);
    endcase
    return u;
  endfunction

  // saturating add or subtract
  function automatic logic signed [DATA_W-1:0] sat_addsub(logic signed [DATA_W-1:0] a,
                                                          logic signed [DATA_W-1:0] b,
                                                          logic sub);
    logic signed [DATA_W:0] s;
    s = sub ? ({a[DATA_W-1], a} - {b[DATA_W-1], b}) : ({a[DATA_W-1], a} + {b[DATA_W-1], b});
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? VMIN : VMAX;
    end
    return s[DATA_W-1:0];
  endfunction

  // magnitude of a signed value
  function automatic logic [DATA_W-1:0] magnitude(logic signed [DATA_W-1:0] a);
    return a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
  endfunction

  // signed result from sign and magnitude, saturated
  function automatic logic signed [DATA_W-1:0] sat_mag(logic neg, logic [MAG_W-1:0] m);
    logic [MAG_W-1:0] limit;
    logic [DATA_W-1:0] lo;
    limit = neg ? (MAG_W'(VMAX) + MAG_W'(1)) : MAG_W'(VMAX);
    lo    = m[DATA_W-1:0];
    if (m > limit) begin
      return neg ? VMIN : VMAX;
    end
    return neg ? (~lo + DATA_W'(1)) : lo;
  endfunction

endpackage

/* sv/rls_self_tuning_estimator_core.sv */
// rls_self_tuning_estimator_core: two-parameter recursive least squares estimator with
// forgetting and pole-placement gains, run by a microcoded sequencer over shared units
// depends on rls_pkg
//
// One item is taken at a time: s_tready is high only while the sequencer is idle, so
// a new item is accepted only after the last result has gone to the result register.
// An update item runs longer than a restart item; a skipped update or a zero gain
// estimate ends sooner. The pace is set by the shared bit-serial divider (six
// quotients in an update and two for the controller gains); every other
// micro-operation runs over one register file read port pair, one multiplier and one
// saturating adder. After reset the block runs the restart program once to set up the
// parameters and covariance and takes no item meanwhile. A result waiting on the master
// side does not hold off the next item; it is only the final hand-over that waits for
// m_tready.
module rls_self_tuning_estimator_core
  import rls_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  // configuration writes
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  // input items
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [95:0]   s_tdata,   // past_output, past_drive, present_output
  input  logic          s_tuser,   // op
  // result items
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [159:0]  m_tdata,   // prediction_error, pole_estimate, gain_estimate,
                                   // feedback_gain, reference_gain
  output logic [1:0]    m_tuser    // update_skipped, gains_invalid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_MULW,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  state_t state;
  logic   boot;
  logic [PC_W-1:0] pc;
  uop_t   uop;

  // configuration
  logic [16:0]              forgetting;
  logic signed [DATA_W-1:0] cfg_a0, cfg_b0, cfg_p1, cfg_p2;
  logic [16:0]              lam_latch;
  logic [16:0]              lam_val;

  // latched input item
  logic signed [DATA_W-1:0] in_y, in_u, in_yc;

  // register file and operands
  logic signed [DATA_W-1:0] rf [2**RF_AW];
  logic signed [DATA_W-1:0] opa, opb;
  logic signed [DATA_W-1:0] spec_a, spec_b;

  // shared multiplier and divider
  logic [2*DATA_W-1:0] prod;
  logic                prod_neg;
  logic [MAG_W-1:0]    div_num, div_q;
  logic [DATA_W-1:0]   div_rem, div_den;
  logic [5:0]          div_cnt;
  logic                div_neg;
  logic [DATA_W:0]     rem_sh;
  logic                rem_ge;
  logic [DATA_W-1:0]   rem_nx;

  // working result
  logic signed [DATA_W-1:0] wk_err, wk_a, wk_b, wk_kfb, wk_kref;
  logic                     wk_skip, wk_inv;

  // write-back
  logic                     wb_en;
  logic signed [DATA_W-1:0] wb_val;

  assign uop      = ucode(pc);
  assign s_tready = (state == ST_IDLE);

  // forgetting factor limited to [2^-16, 1.0]
  always_comb begin
    if (lam_latch == 17'd0) begin
      lam_val = 17'd1;
    end else if (lam_latch > 17'd65536) begin
      lam_val = 17'd65536;
    end else begin
      lam_val = lam_latch;
    end
  end

  // fixed operand sources
  function automatic logic signed [DATA_W-1:0] spec(logic [SEL_W-1:0] s,
      logic signed [DATA_W-1:0] y, logic signed [DATA_W-1:0] u,
      logic signed [DATA_W-1:0] yc, logic [16:0] lam,
      logic signed [DATA_W-1:0] p1, logic signed [DATA_W-1:0] p2,
      logic signed [DATA_W-1:0] a0, logic signed [DATA_W-1:0] b0);
    logic signed [DATA_W-1:0] v;
    case (s)
      S_Y:     v = y;
      S_U:     v = u;
      S_YC:    v = yc;
      S_LAM:   v = DATA_W'(lam);
      S_P1:    v = p1;
      S_P2:    v = p2;
      S_A0:    v = a0;
      S_B0:    v = b0;
      S_HUND:  v = HUNDRED;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign spec_a = spec(uop.srca, in_y, in_u, in_yc, lam_val, cfg_p1, cfg_p2, cfg_a0, cfg_b0);
  assign spec_b = spec(uop.srcb, in_y, in_u, in_yc, lam_val, cfg_p1, cfg_p2, cfg_a0, cfg_b0);

  // divider step: shift one numerator bit into the remainder
  assign rem_sh = {div_rem, div_num[MAG_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_den});
  always_comb begin
    if (rem_ge) begin
      rem_nx = DATA_W'(rem_sh - {1'b0, div_den});
    end else begin
      rem_nx = rem_sh[DATA_W-1:0];
    end
  end

  // write-back value from whichever unit finishes
  always_comb begin
    wb_en  = 1'b0;
    wb_val = '0;
    case (state)
      ST_EXEC: begin
        case (uop.op)
          OP_ADD: begin
            wb_en  = 1'b1;
            wb_val = sat_addsub(opa, opb, 1'b0);
          end
          OP_SUB: begin
            wb_en  = 1'b1;
            wb_val = sat_addsub(opa, opb, 1'b1);
          end
          OP_DIV: begin
            wb_en  = (opb == '0);
            wb_val = opa[DATA_W-1] ? VMIN : VMAX;
          end
          default: ;
        endcase
      end
      ST_MULW: begin
        wb_en  = 1'b1;
        wb_val = sat_mag(prod_neg, prod[2*DATA_W-1:FRAC_W]);
      end
      ST_DIVIDE: begin
        wb_en  = (div_cnt == 6'd0);
        wb_val = sat_mag(div_neg, div_q);
      end
      default: ;
    endcase
  end

  // register file write port and operand read, both registered
  always_ff @(posedge clk) begin
    if (wb_en && !uop.dst[SEL_W-1]) begin
      rf[uop.dst[RF_AW-1:0]] <= wb_val;
    end
    if (state == ST_FETCH) begin
      opa <= uop.srca[SEL_W-1] ? spec_a : rf[uop.srca[RF_AW-1:0]];
      opb <= uop.srcb[SEL_W-1] ? spec_b : rf[uop.srcb[RF_AW-1:0]];
    end
  end

  // sequencer, shared units, configuration and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FETCH;
      boot       <= 1'b1;
      pc         <= PC_RESTART;
      m_tvalid   <= 1'b0;
      forgetting <= 17'd65536;
      lam_latch  <= 17'd65536;
      cfg_a0     <= '0;
      cfg_b0     <= DATA_W'(65536);
      cfg_p1     <= '0;
      cfg_p2     <= '0;
      wk_skip    <= 1'b0;
      wk_inv     <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_FORGETTING: forgetting <= cfg_data[16:0];
          CFG_A0:         cfg_a0     <= cfg_data;
          CFG_B0:         cfg_b0     <= cfg_data;
          CFG_P1:         cfg_p1     <= cfg_data;
          CFG_P2:         cfg_p2     <= cfg_data;
          default: ;
        endcase
      end

      // result taken; the hand-over state reloads it itself
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end

      // destinations outside the register file
      if (wb_en) begin
        case (uop.dst)
          D_ERR:   wk_err  <= wb_val;
          D_A:     wk_a    <= wb_val;
          D_B:     wk_b    <= wb_val;
          D_KFB:   wk_kfb  <= wb_val;
          D_KREF:  wk_kref <= wb_val;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            in_y    <= s_tdata[31:0];
            in_u    <= s_tdata[63:32];
            in_yc   <= s_tdata[95:64];
            wk_err  <= '0;
            wk_kfb  <= '0;
            wk_kref <= '0;
            wk_skip <= 1'b0;
            wk_inv  <= 1'b0;
            if (s_tuser) begin
              lam_latch <= forgetting;
              pc        <= PC_RESTART;
            end else begin
              pc <= PC_UPDATE;
            end
            state <= ST_FETCH;
          end
        end

        ST_FETCH: begin
          state <= ST_EXEC;
        end

        ST_EXEC: begin
          case (uop.op)
            OP_ADD, OP_SUB: begin
              pc    <= pc + PC_W'(1);
              state <= ST_FETCH;
            end
            OP_MUL: begin
              prod     <= magnitude(opa) * magnitude(opb);
              prod_neg <= opa[DATA_W-1] ^ opb[DATA_W-1];
              state    <= ST_MULW;
            end
            OP_DIV: begin
              if (opb == '0) begin
                pc    <= pc + PC_W'(1);
                state <= ST_FETCH;
              end else begin
                div_num <= {magnitude(opa), {FRAC_W{1'b0}}};
                div_den <= magnitude(opb);
                div_rem <= '0;
                div_q   <= '0;
                div_cnt <= 6'(MAG_W);
                div_neg <= opa[DATA_W-1] ^ opb[DATA_W-1];
                state   <= ST_DIVIDE;
              end
            end
            OP_BZS, OP_BZI: begin
              if (opa == '0) begin
                if (uop.op == OP_BZS) begin
                  wk_skip <= 1'b1;
                end else begin
                  wk_inv <= 1'b1;
                end
                pc <= uop.target;
              end else begin
                pc <= pc + PC_W'(1);
              end
              state <= ST_FETCH;
            end
            OP_JMP: begin
              pc    <= uop.target;
              state <= ST_FETCH;
            end
            default: begin
              if (boot) begin
                boot  <= 1'b0;
                state <= ST_IDLE;
              end else begin
                state <= ST_DONE;
              end
            end
          endcase
        end

        ST_MULW: begin
          pc    <= pc + PC_W'(1);
          state <= ST_FETCH;
        end

        // one quotient bit per cycle
        ST_DIVIDE: begin
          if (div_cnt == 6'd0) begin
            pc    <= pc + PC_W'(1);
            state <= ST_FETCH;
          end else begin
            div_rem <= rem_nx;
            div_num <= {div_num[MAG_W-2:0], 1'b0};
            div_q   <= {div_q[MAG_W-2:0], rem_ge};
            div_cnt <= div_cnt - 6'd1;
          end
        end

        // hand the result over once the output register is free
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {wk_kref, wk_kfb, wk_b, wk_a, wk_err};
            m_tuser  <= {wk_inv, wk_skip};
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* verif/rls_estimate_checker.sv */
// rls_estimate_checker: watches the configuration, input and result channels of the
// estimator core, predicts every result in signed Q16.16 and compares it field by field
// depends on rls_pkg
module rls_estimate_checker
  import rls_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [95:0]  s_tdata,   // past_output, past_drive, present_output
  input  logic         s_tuser,   // op
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [159:0] m_tdata,   // prediction_error, pole_estimate, gain_estimate,
                                  // feedback_gain, reference_gain
  input  logic [1:0]   m_tuser,   // update_skipped, gains_invalid
  output int           mismatches,
  output int           waiting,
  output int           n_items,
  output int           n_restarts,
  output int           n_skipped,
  output int           n_invalid
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [DATA_W-1:0] q_t;
  // {update_skipped/gains_invalid, five data words}, same layout as {m_tuser, m_tdata}
  typedef logic [161:0] estimate_t;

  // estimator state and register copies
  q_t          theta [2];
  q_t          cov [4];
  logic [16:0] lam_latch;
  logic [16:0] forget_reg;
  q_t          a0_reg, b0_reg, p1_reg, p2_reg;

  estimate_t expected_estimates [$];
  int err_cnt = 0, item_cnt = 0, restart_cnt = 0, skip_cnt = 0, invalid_cnt = 0;

  assign mismatches = err_cnt;
  assign waiting    = expected_estimates.size();
  assign n_items    = item_cnt;
  assign n_restarts = restart_cnt;
  assign n_skipped  = skip_cnt;
  assign n_invalid  = invalid_cnt;

  // saturating fixed-point arithmetic
  function automatic q_t q_clip(longint v);
    if (v > longint'(VMAX)) return VMAX;
    if (v < longint'(VMIN)) return VMIN;
    return q_t'(v);
  endfunction

  function automatic q_t q_add(q_t a, q_t b);
    return q_clip(longint'(a) + longint'(b));
  endfunction

  function automatic q_t q_sub(q_t a, q_t b);
    return q_clip(longint'(a) - longint'(b));
  endfunction

  function automatic logic [63:0] q_abs(q_t v);
    return (v < 0) ? 64'(-longint'(v)) : 64'(longint'(v));
  endfunction

  function automatic q_t q_from_mag(logic neg, logic [63:0] m);
    if (neg) return (m > 64'h8000_0000) ? VMIN : q_t'(-longint'(m));
    return (m > 64'h7FFF_FFFF) ? VMAX : q_t'(m);
  endfunction

  // product truncated toward zero
  function automatic q_t q_mul(q_t a, q_t b);
    return q_from_mag((a < 0) != (b < 0), (q_abs(a) * q_abs(b)) >> FRAC_W);
  endfunction

  // quotient truncated toward zero, division by zero saturates by dividend sign
  function automatic q_t q_div(q_t n, q_t d);
    if (d == 0) return (n < 0) ? VMIN : VMAX;
    return q_from_mag((n < 0) != (d < 0), (q_abs(n) << FRAC_W) / q_abs(d));
  endfunction

  function automatic q_t lambda_now();
    logic [16:0] f;
    f = lam_latch;
    if (f == 0) f = 17'd1;
    if (f > 17'd65536) f = 17'd65536;
    return q_t'(f);
  endfunction

  // reload parameters and covariance from the registers
  function automatic void reload_estimator();
    theta[0]  = q_sub('0, a0_reg);
    theta[1]  = b0_reg;
    cov[0]    = HUNDRED;
    cov[1]    = '0;
    cov[2]    = '0;
    cov[3]    = HUNDRED;
    lam_latch = forget_reg;
  endfunction

  // one estimator step: update or restart, then estimates and placement gains
  function automatic estimate_t estimate_next(logic op, q_t y, q_t u, q_t yc);
    q_t lam, yhat, pp0, pp1, den, g0, g1, err, a, b, kfb, kref;
    q_t c0, c1, c2, c3;
    logic skipped, invalid;
    err = '0;
    skipped = 1'b0;
    invalid = 1'b0;
    kfb = '0;
    kref = '0;
    if (op) begin
      reload_estimator();
    end else begin
      lam  = lambda_now();
      yhat = q_add(q_mul(theta[0], y), q_mul(theta[1], u));
      pp0  = q_add(q_mul(cov[0], y), q_mul(cov[1], u));
      pp1  = q_add(q_mul(cov[2], y), q_mul(cov[3], u));
      den  = q_add(q_add(lam, q_mul(y, pp0)), q_mul(u, pp1));
      err  = q_sub(yc, yhat);
      if (den == 0) begin
        skipped = 1'b1;
      end else begin
        g0 = q_div(pp0, den);
        g1 = q_div(pp1, den);
        c0 = cov[0];
        c1 = cov[1];
        c2 = cov[2];
        c3 = cov[3];
        theta[0] = q_add(theta[0], q_mul(g0, err));
        theta[1] = q_add(theta[1], q_mul(g1, err));
        cov[0] = q_div(q_sub(c0, q_mul(g0, pp0)), lam);
        cov[1] = q_div(q_sub(c1, q_mul(g0, pp1)), lam);
        cov[2] = q_div(q_sub(c2, q_mul(g1, pp0)), lam);
        cov[3] = q_div(q_sub(c3, q_mul(g1, pp1)), lam);
      end
    end
    a = q_sub('0, theta[0]);
    b = theta[1];
    if (b == 0) begin
      invalid = 1'b1;
    end else begin
      kfb  = q_div(q_sub(q_sub('0, q_add(p1_reg, p2_reg)), a), b);
      kref = q_div(q_mul(p1_reg, p2_reg), b);
    end
    return {invalid, skipped, kref, kfb, b, a, err};
  endfunction

  function automatic longint field_of(estimate_t v, int i);
    if (i < 2) return longint'(v[160+i]);
    return longint'(q_t'(v[32*(i-2) +: 32]));
  endfunction

  // track registers, predict on each input transaction, compare each result
  always @(posedge clk) begin
    string     names [7];
    estimate_t want, got;
    names = '{"update_skipped", "gains_invalid", "prediction_error", "pole_estimate",
              "gain_estimate", "feedback_gain", "reference_gain"};
    if (rst) begin
      forget_reg = 17'd65536;
      a0_reg = '0;
      b0_reg = q_t'(65536);
      p1_reg = '0;
      p2_reg = '0;
      reload_estimator();
      expected_estimates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FORGETTING: forget_reg = cfg_data[16:0];
          CFG_A0:         a0_reg = cfg_data;
          CFG_B0:         b0_reg = cfg_data;
          CFG_P1:         p1_reg = cfg_data;
          CFG_P2:         p2_reg = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want = estimate_next(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
        expected_estimates.push_back(want);
        item_cnt++;
        if (s_tuser) restart_cnt++;
        if (want[160]) skip_cnt++;
        if (want[161]) invalid_cnt++;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        if (expected_estimates.size() == 0) begin
          err_cnt++;
          $display("%0t: result transaction with no estimate pending: %h", $time, got);
        end else begin
          want = expected_estimates.pop_front();
          for (int i = 0; i < 7; i++) begin
            if (field_of(want, i) != field_of(got, i)) begin
              err_cnt++;
              $display("%0t: %s expected %0d actual %0d", $time, names[i],
                       field_of(want, i), field_of(got, i));
            end
          end
        end
      end
    end
  end

endmodule

/* verif/tb_top.sv */
// tb_top: stimulus and verdict for rls_self_tuning_estimator_core
// drives plant-like and edge-case samples, restarts and register settings
// depends on rls_pkg, rls_estimate_checker and the core
module tb_top;
  import rls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [DATA_W-1:0] q_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;   // past_output, past_drive, present_output
  logic         s_tuser = 1'b0; // op
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;        // prediction_error, pole_estimate, gain_estimate,
                                // feedback_gain, reference_gain
  logic [1:0]   m_tuser;        // update_skipped, gains_invalid

  int mismatches, waiting, n_items, n_restarts, n_skipped, n_invalid;
  logic quiet = 1'b0;           // no idling on either side while set
  int   ready_hold = 0;
  longint plant_y, plant_a, plant_b;

  rls_self_tuning_estimator_core DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  rls_estimate_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .mismatches(mismatches), .waiting(waiting), .n_items(n_items),
    .n_restarts(n_restarts), .n_skipped(n_skipped), .n_invalid(n_invalid)
  );

  always #5 clk = ~clk;

  // watchdog
  initial begin
    #30_000_000;
    $display("rls_self_tuning_estimator_core regression: fail");
    $finish;
  end

  // result side stall: new hold drawn per result transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) ready_hold = quiet ? 0 : $urandom_range(0, 13);
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // one input transaction, entered and left at a falling edge
  task automatic send_sample(logic op, q_t y, q_t u, q_t yc);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {yc, u, y};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // wait until every estimate has come back and the sequencer has settled
  task automatic drain();
    s_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic q_t edge_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return q_t'(1);
      2: return -q_t'(1);
      3: return q_t'(65536);
      4: return -q_t'(65536);
      5: return VMAX;
      6: return VMIN;
      default: return q_t'(2);
    endcase
  endfunction

  function automatic q_t clip_plant(longint v);
    if (v > longint'(VMAX)) return VMAX;
    if (v < longint'(VMIN)) return VMIN;
    return q_t'(v);
  endfunction

  // mostly samples from a first-order plant, with restarts, edge values and noise
  task automatic send_random();
    int     pick;
    longint u, y_next;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_sample(1'b1, q_t'($urandom), q_t'($urandom), q_t'($urandom));
    end else if (pick < 18) begin
      send_sample(1'b0, edge_value(), edge_value(), edge_value());
    end else if (pick < 32) begin
      send_sample(1'b0, q_t'($urandom), q_t'($urandom), q_t'($urandom));
    end else begin
      u = longint'($urandom_range(0, 524288)) - 262144;
      y_next = ((plant_a * plant_y) >>> 16) + ((plant_b * u) >>> 16)
             + longint'($urandom_range(0, 64)) - 32;
      send_sample(1'b0, clip_plant(plant_y), q_t'(u), clip_plant(y_next));
      plant_y = clip_plant(y_next);
    end
  endtask

  task automatic set_registers(logic [16:0] forget, q_t a0, q_t b0, q_t p1, q_t p2);
    cfg_write(CFG_FORGETTING, {15'd0, forget});
    cfg_write(CFG_A0, a0);
    cfg_write(CFG_B0, b0);
    cfg_write(CFG_P1, p1);
    cfg_write(CFG_P2, p2);
    // writes beyond the register list must be ignored
    cfg_write(3'($urandom_range(5, 7)), $urandom);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // block runs its restart program after reset
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    plant_y = 0;

    // directed: reset state, extremes, restart, zero regressor
    quiet = 1'b1;
    send_sample(1'b0, '0, '0, '0);
    send_sample(1'b0, q_t'(65536), q_t'(65536), q_t'(131072));
    send_sample(1'b0, VMAX, VMAX, VMIN);
    send_sample(1'b0, VMIN, VMIN, VMAX);
    send_sample(1'b0, VMAX, VMIN, '0);
    send_sample(1'b1, VMAX, VMAX, VMAX);
    send_sample(1'b0, q_t'(1), -q_t'(1), q_t'(1));
    drain();
    // smallest lambda drives the covariance to saturation
    set_registers(17'd1, '0, q_t'(65536), q_t'(32768), q_t'(16384));
    send_sample(1'b1, '0, '0, '0);
    send_sample(1'b0, q_t'(65536), q_t'(65536), q_t'(65536));
    send_sample(1'b0, q_t'(65536), q_t'(65536), '0);
    send_sample(1'b0, q_t'(65536), '0, '0);
    send_sample(1'b0, '0, q_t'(65536), '0);
    send_sample(1'b0, q_t'(65536), -q_t'(65536), '0);
    send_sample(1'b0, -q_t'(65536), q_t'(65536), q_t'(1));
    drain();
    // zero starting gain makes the placement gains invalid
    set_registers(17'd0, VMAX, '0, VMIN, VMIN);
    send_sample(1'b1, '0, '0, '0);
    send_sample(1'b0, '0, '0, '0);
    send_sample(1'b0, q_t'(65536), '0, q_t'(65536));
    drain();

    // random phases across register settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_registers(17'd65536, '0, q_t'(65536), q_t'(32768), q_t'(16384));
        1: set_registers(17'd1, VMIN, VMAX, VMAX, VMAX);
        2: set_registers(17'd131071, q_t'(-32768), q_t'(-131072), q_t'(-19661),
                         q_t'(39322));
        3: set_registers(17'd62259, q_t'($urandom_range(0, 131072)) - q_t'(65536),
                         q_t'($urandom_range(1, 262144)), q_t'($urandom), q_t'($urandom));
        4: set_registers(17'd0, VMAX, '0, VMIN, VMIN);
        default: set_registers(17'($urandom_range(1, 65536)), q_t'($urandom),
                               q_t'($urandom), q_t'($urandom), q_t'($urandom));
      endcase
      quiet = (phase % 3 == 1);
      plant_a = longint'($urandom_range(0, 117964)) - 58982;
      plant_b = longint'($urandom_range(16384, 131072));
      plant_y = 0;
      send_sample(1'b1, '0, '0, '0);
      for (int k = 0; k < 200; k++) send_random();
      drain();
    end

    $display("covered %0d transactions: %0d restarts, %0d skipped updates, %0d invalid gains",
             n_items, n_restarts, n_skipped, n_invalid);
    $display("register settings swept: 9, lambda from out-of-range low to out-of-range high");
    if (mismatches == 0 && waiting == 0) begin
      $display("rls_self_tuning_estimator_core regression: pass");
    end else begin
      $display("rls_self_tuning_estimator_core regression: fail");
    end
    $finish;
  end

endmodule
